>>> sv/mptw_pkg.sv
// Package for the multilevel page table walker: sizes, codes, and the
// structs for frame memory accesses and walk results.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mptw_pkg;

  // Table geometry
  localparam int NUM_FRAMES = 64;
  localparam int LEVELS     = 5;
  localparam int IDX_BITS   = 9;
  localparam int ENTRIES    = 1 << IDX_BITS;
  localparam int DEPTH      = NUM_FRAMES * ENTRIES;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int VPN_W    = 45;
  localparam int VPN_USE_W = IDX_BITS * LEVELS;
  localparam int PN_W     = 52;
  localparam int ENTRY_W  = PN_W + 1;
  localparam int ROOT_W   = 6;
  localparam int FFREE_W  = 7;
  localparam int FRAME_W  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int ADDR_W   = FRAME_W + IDX_BITS;
  localparam int ALLOC_W  = $clog2(NUM_FRAMES + 1);
  localparam int CAND_W   = ((FFREE_W > ALLOC_W) ? FFREE_W : ALLOC_W) + 1;
  localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  // Stream packing
  localparam int IN_TDATA_W  = ((VPN_W + PN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((PN_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = FFREE_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_QUERY = 2'd0,
    MODE_MAP   = 2'd1,
    MODE_UNMAP = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOT_FRAME = 1'b0,
    CFG_FIRST_FREE = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_LEAF,
    ST_DONE
  } walk_state_t;

  // One access to the frame memory
  typedef struct packed {
    logic               en;
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
  } mem_req_t;

  // Outcome of one walk
  typedef struct packed {
    logic            found;
    logic [PN_W-1:0] ppn;
    logic            out_of_frames;
  } walk_result_t;

  // Table index used at a given level, highest index first
  function automatic logic [IDX_BITS-1:0] idx_of(input logic [VPN_USE_W-1:0] vpn,
                                                 input logic [LVL_W-1:0] lvl);
    logic [IDX_BITS-1:0] r;
    r = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if (lvl == LVL_W'(l)) r = vpn[IDX_BITS*(LEVELS-1-l) +: IDX_BITS];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/mptw_frame_mem.sv
// Frame memory of the page table walker: single-port synchronous RAM,
// one read or one write per cycle, registered read data. Uses mptw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mptw_frame_mem
  import mptw_pkg::*;
(
  input  wire logic               clk,
  input  wire mem_req_t           req,
  output logic      [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  // Write or read; read data is registered
  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rdata <= mem[req.addr];
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/mptw_walk_ctrl.sv
// Walk sequencer: clears the frame memory after reset, then walks the table
// level by level, allocating frames and writing leaves. Uses mptw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mptw_walk_ctrl
  import mptw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // request side
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire mode_t               req_mode,
  input  wire logic [VPN_USE_W-1:0] req_vpn,
  input  wire logic [PN_W-1:0]     req_ppn,
  // configuration
  input  wire logic [ROOT_W-1:0]   root_frame,
  input  wire logic [FFREE_W-1:0]  first_free_frame,
  // result side
  output logic                     res_valid,
  input  wire logic                res_ready,
  output walk_result_t             res,
  // frame memory
  output mem_req_t                 mem_req,
  input  wire logic [ENTRY_W-1:0]  mem_rdata
);

  walk_state_t          state, state_next;
  logic [ADDR_W-1:0]    clr_addr, clr_addr_next;
  logic [ALLOC_W-1:0]   allocated, allocated_next;
  mode_t                mode, mode_next;
  logic [VPN_USE_W-1:0] vpn, vpn_next;
  logic [PN_W-1:0]      ppn, ppn_next;
  logic [LVL_W-1:0]     lvl, lvl_next;
  logic [FRAME_W-1:0]   frame, frame_next;
  walk_result_t         res_next;

  logic [ADDR_W-1:0]    cur_addr;
  logic                 root_ok;
  logic                 ent_valid;
  logic [PN_W-1:0]      ent_pn;
  logic                 ptr_ok;
  logic [CAND_W-1:0]    cand;
  logic                 cand_ok;

  assign cur_addr  = {frame, idx_of(vpn, lvl)};
  assign root_ok   = PN_W'(root_frame) < PN_W'(NUM_FRAMES);
  assign ent_valid = mem_rdata[PN_W];
  assign ent_pn    = mem_rdata[PN_W-1:0];
  assign ptr_ok    = ent_pn < PN_W'(NUM_FRAMES);
  assign cand      = CAND_W'(first_free_frame) + CAND_W'(allocated);
  assign cand_ok   = cand < CAND_W'(NUM_FRAMES);

  // State and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      allocated <= '0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      allocated <= allocated_next;
    end
    mode  <= mode_next;
    vpn   <= vpn_next;
    ppn   <= ppn_next;
    lvl   <= lvl_next;
    frame <= frame_next;
    res   <= res_next;
  end

  // Next state and memory accesses
  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    allocated_next = allocated;
    mode_next      = mode;
    vpn_next       = vpn;
    ppn_next       = ppn;
    lvl_next       = lvl;
    frame_next     = frame;
    res_next       = res;
    req_ready      = 1'b0;
    res_valid      = 1'b0;
    mem_req        = '0;

    case (state)
      // zero one entry per cycle after reset
      ST_CLEAR: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_addr;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = ST_IDLE;
      end

      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          mode_next  = req_mode;
          vpn_next   = req_vpn;
          ppn_next   = req_ppn;
          lvl_next   = '0;
          frame_next = FRAME_W'(root_frame);
          res_next   = '0;
          case (req_mode)
            MODE_QUERY: state_next = root_ok ? ST_READ : ST_DONE;
            MODE_MAP, MODE_UNMAP: begin
              if (!root_ok) begin
                res_next.out_of_frames = 1'b1;
                state_next = ST_DONE;
              end else if (LEVELS == 1) begin
                state_next = ST_LEAF;
              end else begin
                state_next = ST_READ;
              end
            end
            default: state_next = ST_DONE;
          endcase
        end
      end

      ST_READ: begin
        mem_req.en   = 1'b1;
        mem_req.addr = cur_addr;
        state_next   = ST_CHECK;
      end

      // entry of the current level is in mem_rdata
      ST_CHECK: begin
        if (mode == MODE_QUERY) begin
          if (!ent_valid) begin
            state_next = ST_DONE;
          end else if (lvl == LVL_W'(LEVELS - 1)) begin
            res_next.found = 1'b1;
            res_next.ppn   = ent_pn;
            state_next     = ST_DONE;
          end else if (!ptr_ok) begin
            state_next = ST_DONE;
          end else begin
            frame_next = FRAME_W'(ent_pn);
            lvl_next   = lvl + 1'b1;
            state_next = ST_READ;
          end
        end else begin
          if (ent_valid && ptr_ok) begin
            frame_next = FRAME_W'(ent_pn);
            lvl_next   = lvl + 1'b1;
            state_next = (lvl + 1'b1 == LVL_W'(LEVELS - 1)) ? ST_LEAF : ST_READ;
          end else if (!cand_ok) begin
            res_next.out_of_frames = 1'b1;
            state_next = ST_DONE;
          end else begin
            // link a fresh frame in place of the missing pointer
            mem_req.en     = 1'b1;
            mem_req.we     = 1'b1;
            mem_req.addr   = cur_addr;
            mem_req.wdata  = {1'b1, PN_W'(cand)};
            allocated_next = allocated + 1'b1;
            frame_next     = FRAME_W'(cand);
            lvl_next       = lvl + 1'b1;
            state_next = (lvl + 1'b1 == LVL_W'(LEVELS - 1)) ? ST_LEAF : ST_READ;
          end
        end
      end

      ST_LEAF: begin
        mem_req.en    = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.addr  = cur_addr;
        mem_req.wdata = (mode == MODE_MAP) ? {1'b1, ppn} : '0;
        state_next    = ST_DONE;
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_next = ST_IDLE;
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/multilevel_page_table_walker_core.sv
// Multilevel page table walker, top level: stream ports, configuration
// registers, output register. Uses mptw_pkg, mptw_walk_ctrl, mptw_frame_mem.
//
// Usage:
//  - Requests arrive on the s_* stream: s_tuser carries the mode (query, map,
//    unmap), s_tdata the virtual page number and the page number to map.
//  - Each request yields exactly one transaction on the m_* stream: m_tdata
//    carries the found page number, m_tuser the found and out_of_frames flags.
//  - cfg_* writes root_frame (index 0) and first_free_frame (index 1); it is
//    always ready and the value takes effect at once.
//  - Timing: each level read takes an address state and a data state
//    (ST_READ, ST_CHECK) on the frame memory's single port; map and unmap end
//    with a leaf write (ST_LEAF). One request at a time; s_tready is high only
//    while idle, so the next request is taken only after the walk has finished
//    and its result has been handed to the output register.
//  - After reset the frame memory is swept to zero, one entry per cycle, all
//    NUM_FRAMES * 512 = 32768 entries, with s_tready low. Configuration writes
//    are taken during the sweep.
//  - The result sits in an output register. If the receiver stalls, the
//    walker still takes the next request and finishes its walk, then holds
//    its result until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module multilevel_page_table_walker_core
  import mptw_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // request stream
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // vpn[44:0], ppn[96:45], zero pad
  input  wire logic [MODE_W-1:0]      s_tuser,   // mode[1:0]
  // result stream
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [OUT_TDATA_W-1:0] m_tdata,   // result_ppn[51:0], zero pad
  output logic      [OUT_TUSER_W-1:0] m_tuser,   // found[0], out_of_frames[1]
  // configuration write channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [ROOT_W-1:0]  root_frame;
  logic [FFREE_W-1:0] first_free_frame;
  logic               res_valid;
  logic               res_ready;
  walk_result_t       res;
  walk_result_t       out_res;
  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] mem_rdata;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_frame       <= '0;
      first_free_frame <= FFREE_W'(1);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ROOT_FRAME: root_frame       <= cfg_data[ROOT_W-1:0];
        CFG_FIRST_FREE: first_free_frame <= cfg_data[FFREE_W-1:0];
        default: ;
      endcase
    end
  end

  mptw_walk_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (s_tvalid),
    .req_ready        (s_tready),
    .req_mode         (mode_t'(s_tuser)),
    .req_vpn          (s_tdata[VPN_USE_W-1:0]),
    .req_ppn          (s_tdata[VPN_W +: PN_W]),
    .root_frame       (root_frame),
    .first_free_frame (first_free_frame),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res),
    .mem_req          (mem_req),
    .mem_rdata        (mem_rdata)
  );

  mptw_frame_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // Output register
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
    if (res_ready && res_valid) out_res <= res;
  end

  assign m_tdata = OUT_TDATA_W'(out_res.ppn);
  assign m_tuser = {out_res.out_of_frames, out_res.found};

endmodule
`default_nettype wire

>>> sv/mptw_checker.sv
// Port-level checker for the page table walker, bound to the top level.
// Uses mptw_pkg for port widths.
`timescale 1ns / 1ps
`default_nettype none
module mptw_checker
  import mptw_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_tvalid,
  input wire logic                   s_tready,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [OUT_TDATA_W-1:0] m_tdata,
  input wire logic [OUT_TUSER_W-1:0] m_tuser
);

  // a hit never reports exhaustion
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("found and out_of_frames both set");

  // page number is zero unless a query hit
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
    else $error("nonzero page number without a hit");

  // one request at a time: no accept in the cycle right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while a walk is running");

  // memory sweep keeps requests out right after reset
  a_reset_blocks: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("request port open during memory clear");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

endmodule

bind multilevel_page_table_walker_core mptw_checker u_mptw_checker (.*);
`default_nettype wire
